### hw/rtl/tama_pkg.sv
// ----------------------------------------------------------------------------
// tama_pkg
// shared types and constants of the three-axis moving average filter
// ----------------------------------------------------------------------------
package tama_pkg;

   localparam int CSR_BITS = 15;
   localparam logic [CSR_BITS-1:0] RESET_WINDOW = 15'd10000;

   typedef struct packed {
      logic clear;      // window write: sum back to zero
      logic load;       // input transfer: read oldest, store newest
      logic old_valid;  // ring slot holds a written sample
      logic delta;      // form newest minus oldest
      logic accum;      // fold difference into running sum
      logic div_load;   // split sign and magnitude, seed divider
      logic div_step;   // one quotient bit
   } lane_ctrl_type;

endpackage

### hw/rtl/tama_div.sv
// ----------------------------------------------------------------------------
// tama_div
// bit-serial restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module tama_div
   import tama_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int WIN_BITS    = 15,
   parameter int SUM_BITS    = 38
) (
   input  logic                   clock,
   input  lane_ctrl_type          ctrl,
   input  logic [SUM_BITS-1:0]    dividend,
   input  logic [WIN_BITS-1:0]    divisor,
   output logic [SAMPLE_BITS-1:0] quotient
);

   logic [WIN_BITS-1:0]    rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] shf_ff, shf_in;
   logic [WIN_BITS:0]      trial;
   logic [WIN_BITS:0]      diff;

   assign trial = {rem_ff, shf_ff[SAMPLE_BITS-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      shf_in = shf_ff;
      if (ctrl.div_load) begin
         rem_in = WIN_BITS'(dividend[SUM_BITS-1:SAMPLE_BITS]);
         shf_in = dividend[SAMPLE_BITS-1:0];
      end else if (ctrl.div_step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[WIN_BITS-1:0];
            shf_in = {shf_ff[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[WIN_BITS-1:0];
            shf_in = {shf_ff[SAMPLE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
   end

   assign quotient = shf_ff;

endmodule

### hw/rtl/tama_lane.sv
// ----------------------------------------------------------------------------
// tama_lane
// one axis: sample history ring, running sum and serial mean divider
// ----------------------------------------------------------------------------
module tama_lane
   import tama_pkg::*;
#(
   parameter int MAX_WINDOW  = 16384,
   parameter int SAMPLE_BITS = 24,
   parameter int WIN_BITS    = 15,
   parameter int POS_BITS    = 14,
   parameter int SUM_BITS    = 38
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctrl_type                 ctrl,
   input  logic [WIN_BITS-1:0]           window,
   input  logic [POS_BITS-1:0]           pos,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic [SAMPLE_BITS-1:0]        mean
);

   logic [SAMPLE_BITS-1:0]        hist [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic signed [SAMPLE_BITS-1:0] new_ff;
   logic                          oldv_ff;
   logic signed [SAMPLE_BITS:0]   delta_ff, delta_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                          neg_ff, neg_in;
   logic [SUM_BITS-1:0]           mag;
   logic [SAMPLE_BITS-1:0]        quotient;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         old_ff    <= hist[pos];
         hist[pos] <= sample;
         new_ff    <= sample;
         oldv_ff   <= ctrl.old_valid;
      end
   end

   always_comb begin
      delta_in = delta_ff;
      if (ctrl.delta) begin
         if (oldv_ff) begin
            delta_in = (SAMPLE_BITS+1)'(new_ff) - (SAMPLE_BITS+1)'(old_ff);
         end else begin
            delta_in = (SAMPLE_BITS+1)'(new_ff);
         end
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.accum) begin
         sum_in = sum_ff + SUM_BITS'(delta_ff);
      end
   end

   assign mag    = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign neg_in = ctrl.div_load ? sum_ff[SUM_BITS-1] : neg_ff;

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      neg_ff   <= neg_in;
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   tama_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WIN_BITS    (WIN_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_div (
      .clock    (clock),
      .ctrl     (ctrl),
      .dividend (mag),
      .divisor  (window),
      .quotient (quotient)
   );

   assign mean = neg_ff ? SAMPLE_BITS'(-quotient) : quotient;

endmodule

### hw/rtl/three_axis_moving_average.sv
// ----------------------------------------------------------------------------
// three_axis_moving_average
// boxcar mean over the last window_length samples of three axes
// one item at a time: no new input is taken until the previous result has
//    entered the output register; the bit-serial divider yields one quotient
//    bit per cycle, axes in parallel
// reset: window 10000, sums and ring index cleared; no clearing pass, a fill
//    flag makes unwritten ring slots read as zero until the ring first wraps
// ----------------------------------------------------------------------------
module three_axis_moving_average
   import tama_pkg::*;
#(
   parameter int MAX_WINDOW  = 16384,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // x_sample, y_sample, z_sample, zero fill
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // x_average, y_average, z_average, zero fill
   output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_BITS-1:0]                    csr_data
);

   localparam int DATA_BITS = ((3*SAMPLE_BITS+7)/8)*8;
   localparam int WIN_BITS  = $clog2(MAX_WINDOW+1);
   localparam int POS_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_BITS  = SAMPLE_BITS + POS_BITS;
   localparam int CNT_BITS  = $clog2(SAMPLE_BITS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DELTA = 3'd1;
   localparam logic [2:0] S_SUM   = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   function automatic logic [WIN_BITS-1:0] clamp_window(input logic [CSR_BITS-1:0] v);
      logic [WIN_BITS-1:0] w;
      if (v == '0) begin
         w = WIN_BITS'(1);
      end else if (32'(v) > MAX_WINDOW) begin
         w = WIN_BITS'(MAX_WINDOW);
      end else begin
         w = WIN_BITS'(v);
      end
      return w;
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WIN_BITS-1:0]  window_ff, window_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic                 wrapped_ff, wrapped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [WIN_BITS-1:0]  pos_inc;
   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 out_load;
   lane_ctrl_type        ctrl;
   logic [SAMPLE_BITS-1:0] x_mean, y_mean, z_mean;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_xfer   = csr_valid & csr_ready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign pos_inc    = WIN_BITS'(pos_ff) + WIN_BITS'(1);

   always_comb begin
      ctrl.clear     = csr_xfer;
      ctrl.load      = req_xfer;
      ctrl.old_valid = wrapped_ff;
      ctrl.delta     = (state_ff == S_DELTA);
      ctrl.accum     = (state_ff == S_SUM);
      ctrl.div_load  = (state_ff == S_LOAD);
      ctrl.div_step  = (state_ff == S_DIV);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_DELTA;
            end
         end
         S_DELTA: state_in = S_SUM;
         S_SUM:   state_in = S_LOAD;
         S_LOAD: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(SAMPLE_BITS-1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      window_in  = window_ff;
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      priority if (csr_xfer) begin
         window_in  = clamp_window(csr_data);
         pos_in     = '0;
         wrapped_in = 1'b0;
      end else if (req_xfer) begin
         if (pos_inc == window_ff) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_inc[POS_BITS-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = DATA_BITS'({z_mean, y_mean, x_mean});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= clamp_window(RESET_WINDOW);
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   tama_lane #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .WIN_BITS    (WIN_BITS),
      .POS_BITS    (POS_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .window (window_ff),
      .pos    (pos_ff),
      .sample (req_tdata[SAMPLE_BITS-1:0]),
      .mean   (x_mean)
   );

   tama_lane #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .WIN_BITS    (WIN_BITS),
      .POS_BITS    (POS_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .window (window_ff),
      .pos    (pos_ff),
      .sample (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .mean   (y_mean)
   );

   tama_lane #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .WIN_BITS    (WIN_BITS),
      .POS_BITS    (POS_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .window (window_ff),
      .pos    (pos_ff),
      .sample (req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .mean   (z_mean)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ring index stays inside the window
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      WIN_BITS'(pos_ff) < window_ff)
      else $error("ring index outside window");

   // an input transfer starts the sequence, no second transfer follows at once
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken while busy");

   // a result appears only from the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result without finished division");

   // wrapping the ring marks every slot as written
   a_fill_flag: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !csr_xfer && pos_inc == window_ff) |=> wrapped_ff)
      else $error("fill flag not set on wrap");

endmodule

### tb/three_axis_moving_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_tb
// self-checking bench for the three-axis boxcar mean: a short table of
// directed samples and window writes, then random phases over several window
// lengths and idling mixes, each result checked against the table or a local model
// ----------------------------------------------------------------------------
module three_axis_moving_average_tb
   import tama_pkg::*;
;

   localparam int MAX_WINDOW  = 16384;
   localparam int SAMPLE_BITS = 24;
   localparam int DATA_BITS   = ((3*SAMPLE_BITS+7)/8)*8;
   localparam int TAIL_CYCLES = SAMPLE_BITS + 10;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 95;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type z;
      sample_type y;
      sample_type x;
   } axis_triple_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic                is_window;
      logic [CSR_BITS-1:0] window;
      axis_triple_type     samples;
      logic                typed;
      axis_triple_type     average;
   } directed_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_BITS-1:0]  csr_data   = '0;

   // local copy of the filter state
   logic signed [SAMPLE_BITS-1:0] axis_history [3][MAX_WINDOW];
   longint                        axis_sum [3];
   int unsigned                   ring_slot;
   int unsigned                   window_len;

   axis_triple_type average_queue [$];
   int              mismatches = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 15'd0,     '{24'h000000, 24'h800000, 24'h7fffff}, 1'b1,
        '{24'h000000, 24'hfffcba, 24'h000346}},
      '{1'b0, 15'd0,     '{24'h000001, 24'h800000, 24'h7fffff}, 1'b1,
        '{24'h000000, 24'hfff973, 24'h00068d}},
      '{1'b1, 15'd0,     '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h800000, 24'hfedcba, 24'h123456}, 1'b1,
        '{24'h800000, 24'hfedcba, 24'h123456}},
      '{1'b0, 15'd0,     '{24'hffffff, 24'h000000, 24'h7fffff}, 1'b1,
        '{24'hffffff, 24'h000000, 24'h7fffff}},
      '{1'b1, 15'd1,     '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h000001, 24'h7fffff, 24'h800000}, 1'b1,
        '{24'h000001, 24'h7fffff, 24'h800000}},
      '{1'b1, 15'd2,     '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'hffffff, 24'h800000, 24'h7fffff}, 1'b1,
        '{24'h000000, 24'hc00000, 24'h3fffff}},
      '{1'b0, 15'd0,     '{24'hffffff, 24'h800000, 24'h7fffff}, 1'b1,
        '{24'hffffff, 24'h800000, 24'h7fffff}},
      '{1'b0, 15'd0,     '{24'h000000, 24'h000000, 24'h000000}, 1'b1,
        '{24'h000000, 24'hc00000, 24'h3fffff}},
      '{1'b0, 15'd0,     '{24'h000003, 24'hffffff, 24'h000001}, 1'b1,
        '{24'h000001, 24'h000000, 24'h000000}},
      '{1'b1, 15'd3,     '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h400000, 24'hfffffb, 24'h000005}, 1'b0,
        '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h000007, 24'h800001, 24'h7ffffe}, 1'b0,
        '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'hc00000, 24'hfffff0, 24'h000010}, 1'b0,
        '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h000002, 24'h000002, 24'h000002}, 1'b0,
        '{24'h0, 24'h0, 24'h0}},
      '{1'b1, 15'd32767, '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h000000, 24'h800000, 24'h7fffff}, 1'b1,
        '{24'h000000, 24'hfffe00, 24'h0001ff}},
      '{1'b0, 15'd0,     '{24'h0f0f0f, 24'haaaaaa, 24'h555555}, 1'b0,
        '{24'h0, 24'h0, 24'h0}},
      '{1'b1, 15'd16385, '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h7fffff, 24'h7fffff, 24'h7fffff}, 1'b0,
        '{24'h0, 24'h0, 24'h0}},
      '{1'b1, 15'd16384, '{24'h0, 24'h0, 24'h0}, 1'b0, '{24'h0, 24'h0, 24'h0}},
      '{1'b0, 15'd0,     '{24'h800000, 24'h800000, 24'h800000}, 1'b1,
        '{24'hfffe00, 24'hfffe00, 24'hfffe00}}
   };

   three_axis_moving_average #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void load_window(input logic [CSR_BITS-1:0] value);
      window_len = (value == 0) ? 1 : (value > MAX_WINDOW) ? MAX_WINDOW : value;
      for (int a = 0; a < 3; a++) begin
         axis_sum[a] = 0;
         for (int i = 0; i < MAX_WINDOW; i++)
            axis_history[a][i] = '0;
      end
      ring_slot = 0;
   endfunction

   function automatic axis_triple_type next_average(input axis_triple_type s);
      logic signed [SAMPLE_BITS-1:0] smp [3];
      longint                        mean [3];
      int unsigned                   pos;
      axis_triple_type               avg;
      smp[0] = s.x;
      smp[1] = s.y;
      smp[2] = s.z;
      pos = (ring_slot >= window_len) ? 0 : ring_slot;
      for (int a = 0; a < 3; a++) begin
         axis_sum[a] = axis_sum[a] - axis_history[a][pos];
         axis_history[a][pos] = smp[a];
         axis_sum[a] = axis_sum[a] + smp[a];
         mean[a] = axis_sum[a] / longint'(window_len);
      end
      pos++;
      ring_slot = (pos >= window_len) ? 0 : pos;
      avg.x = mean[0][SAMPLE_BITS-1:0];
      avg.y = mean[1][SAMPLE_BITS-1:0];
      avg.z = mean[2][SAMPLE_BITS-1:0];
      return avg;
   endfunction

   function automatic sample_type random_sample();
      int         near_zero;
      sample_type v;
      near_zero = int'($urandom_range(0, 200)) - 100;
      case ($urandom_range(0, 9))
         0: begin
            v = 24'h7fffff;
         end
         1: begin
            v = 24'h800000;
         end
         2: begin
            v = near_zero[SAMPLE_BITS-1:0];
         end
         default: begin
            v = SAMPLE_BITS'($urandom());
         end
      endcase
      return v;
   endfunction

   function automatic void set_idling(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 70 : (mode == IDLE_BOTH) ? 29 : 0;
      stall_pct     = (mode == IDLE_RECEIVER) ? 70 : (mode == IDLE_BOTH) ? 29 : 0;
   endfunction

   // sender stops and waits for every outstanding average
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (average_queue.size() != 0);
   endtask

   task automatic write_window(input logic [CSR_BITS-1:0] value);
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      load_window(value);
   endtask

   task automatic send_sample(input axis_triple_type s, input logic typed,
                              input axis_triple_type typed_avg);
      axis_triple_type avg;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do
         @(posedge clock);
      while (!req_tready);
      avg = next_average(s);
      average_queue.push_back(typed ? typed_avg : avg);
   endtask

   always @(posedge clock) begin : result_monitor
      axis_triple_type got;
      axis_triple_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (average_queue.size() == 0) begin
               $error("rsp transfer with no average pending: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = average_queue.pop_front();
               if (got.x !== want.x) begin
                  $error("x_average expected %0d actual %0d", $signed(want.x),
                         $signed(got.x));
                  mismatches++;
               end
               if (got.y !== want.y) begin
                  $error("y_average expected %0d actual %0d", $signed(want.y),
                         $signed(got.y));
                  mismatches++;
               end
               if (got.z !== want.z) begin
                  $error("z_average expected %0d actual %0d", $signed(want.z),
                         $signed(got.z));
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #(10_000_000);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      axis_triple_type     s;
      logic [CSR_BITS-1:0] w;
      load_window(RESET_WINDOW);
      set_idling(IDLE_NONE);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].is_window) begin
            write_window(directed_rows[i].window);
         end else begin
            send_sample(directed_rows[i].samples, directed_rows[i].typed,
                        directed_rows[i].average);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: w = 15'd1;
            1: w = 15'd7;
            2: w = 15'd0;
            3: w = 15'd16384;
            4: w = 15'd3;
            5: w = 15'd32767;
            6: w = CSR_BITS'($urandom_range(1, 64));
            7: w = 15'd2;
            8: w = 15'd16385;
            default: w = CSR_BITS'($urandom_range(1, 300));
         endcase
         write_window(w);
         set_idling(idle_mode_type'(p % 4));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until the pipeline is empty, mid phase
            if (p == 4 && n == 50)
               drain_results();
            s.x = random_sample();
            s.y = random_sample();
            s.z = random_sample();
            send_sample(s, 1'b0, s);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
